[rtl/igl_pkg.sv]
// ---------------------------------------------------------------------------
// igl_pkg
// Shared constants and types of the integer gcd / lcm unit.
// ---------------------------------------------------------------------------
package igl_pkg;

   // default operand width
   localparam int WIDTH_DEFAULT = 32;

   // operation select codes
   localparam logic OP_GCD = 1'b0;
   localparam logic OP_LCM = 1'b1;

   // status of the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/integer_gcd_lcm_unit.sv]
// ---------------------------------------------------------------------------
// integer_gcd_lcm_unit
// Gcd or lcm of two signed integers, one word at a time.
//
// The request channel carries req_op (gcd or lcm) and two signed operands
// req_a and req_b; a word is taken when req_valid is high and req_stall
// low. The unit works on one word at a time and holds req_stall high from
// the cycle after a word is taken until its result is in the output
// register, and the next word can be taken from then on. Gcd works
// on the operand magnitudes with Euclid's algorithm; each remainder step
// runs the shared restoring divider. Unless both operands are zero, lcm
// adds one more division (|a| / gcd, after the last zero check) and a
// shift-add multiply by |b| plus a sign fix-up step. The longest 32-bit
// Euclid chain has 45 steps. The result stays in rsp_result with
// rsp_valid high while rsp_stall is high; a finished result waits in the
// sequencer until the output register is free. Synchronous reset drops
// any item at work and clears rsp_valid.
// ---------------------------------------------------------------------------
module integer_gcd_lcm_unit #(
   parameter int WIDTH = igl_pkg::WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_op,
   input  logic signed [WIDTH-1:0] req_a,
   input  logic signed [WIDTH-1:0] req_b,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WIDTH-1:0] rsp_result
);

   localparam int CW = $clog2(WIDTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_GCD_CHECK,
      S_GCD_WAIT,
      S_DIV_WAIT,
      S_MUL,
      S_FIX,
      S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic             op_ff, op_in;
   logic [WIDTH-1:0] ma_ff, ma_in;
   logic [WIDTH-1:0] mb_ff, mb_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_result_ff, rsp_result_in;
   logic [WIDTH-1:0] mag_a, mag_b;

   logic                    div_start;
   logic [WIDTH-1:0]        div_dividend, div_divisor;
   logic [WIDTH-1:0]        div_quotient, div_remainder;
   igl_pkg::div_status_type div_status;

   // shared divider for Euclid steps and the lcm quotient
   igl_divider #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // operand magnitudes, most negative value wraps to 2^(WIDTH-1)
   assign mag_a = req_a[WIDTH-1] ? ('0 - req_a) : req_a;
   assign mag_b = req_b[WIDTH-1] ? ('0 - req_b) : req_b;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      rsp_result_in = rsp_result_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      div_start     = 1'b0;
      div_dividend  = y_ff;
      div_divisor   = x_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               ma_in    = mag_a;
               mb_in    = mag_b;
               x_in     = mag_a;
               y_in     = mag_b;
               state_in = S_GCD_CHECK;
            end
         end
         S_GCD_CHECK: begin
            if (x_ff != '0) begin
               div_start = 1'b1;
               state_in  = S_GCD_WAIT;
            end else if (op_ff == igl_pkg::OP_GCD || y_ff == '0) begin
               acc_in   = (op_ff == igl_pkg::OP_GCD) ? y_ff : '0;
               state_in = S_FINISH;
            end else begin
               div_start    = 1'b1;
               div_dividend = ma_ff;
               div_divisor  = y_ff;
               state_in     = S_DIV_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (div_status.done) begin
               y_in     = x_ff;
               x_in     = div_remainder;
               state_in = S_GCD_CHECK;
            end
         end
         S_DIV_WAIT: begin
            if (div_status.done) begin
               x_in     = div_quotient;
               y_in     = mb_ff;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // shift-add, one multiplier bit per cycle, modulo 2^WIDTH
            acc_in = acc_ff + (y_ff[0] ? x_ff : '0);
            x_in   = {x_ff[WIDTH-2:0], 1'b0};
            y_in   = {1'b0, y_ff[WIDTH-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(WIDTH - 1)) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            // two's complement abs, most negative pattern stays
            acc_in   = acc_ff[WIDTH-1] ? ('0 - acc_ff) : acc_ff;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      acc_ff        <= acc_in;
      cnt_ff        <= cnt_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = $signed(rsp_result_ff);

   // divider finishes only while the sequencer waits for it
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_GCD_WAIT || state_ff == S_DIV_WAIT))
      else $error("divider done outside a wait state");

   // a new result appears only out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(state_ff) == S_FINISH)
      else $error("result word without finish state");

   // finished Euclid step returns to the zero check
   a_gcd_step_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GCD_WAIT && div_status.done) |=> state_ff == S_GCD_CHECK)
      else $error("euclid step did not return to check");

   // divider is never restarted while busy
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

endmodule

[rtl/igl_divider.sv]
// ---------------------------------------------------------------------------
// igl_divider
// Restoring unsigned divider, one quotient bit per cycle. Quotient and
// remainder hold until the next start.
// ---------------------------------------------------------------------------
module igl_divider #(
   parameter int WIDTH = igl_pkg::WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [WIDTH-1:0]       dividend,
   input  logic [WIDTH-1:0]       divisor,
   output logic [WIDTH-1:0]       quotient,
   output logic [WIDTH-1:0]       remainder,
   output igl_pkg::div_status_type status
);

   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   rem_sh;
   logic [WIDTH:0]   rem_sub;
   logic             ge;

   // one shift and trial subtract
   assign rem_sh  = {rem_ff, quo_ff[WIDTH-1]};
   assign ge      = (rem_sh >= {1'b0, dvs_ff});
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], ge};
         rem_in = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[tb/integer_gcd_lcm_unit_test.sv]
// ---------------------------------------------------------------------------
// integer_gcd_lcm_unit_test
// Self-checking bench for the gcd / lcm unit. A short table of corner words
// (zero operands, most negative and most positive values, lcm wrap-around,
// the longest Euclid chain) runs first. Random words of several operand
// classes follow, with random gaps and stalls on both channels, a stretch
// with none, and a long output hold that backs up the request channel.
// Every result is checked in order, against the hand-typed corner value
// where there is one, else against a gcd / lcm calculator kept in the bench.
// ---------------------------------------------------------------------------
module integer_gcd_lcm_unit_test;

   localparam int WIDTH = igl_pkg::WIDTH_DEFAULT;
   localparam logic [WIDTH-1:0] MIN_VALUE = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MAX_VALUE = {1'b0, {(WIDTH-1){1'b1}}};

   // one row of the corner table; known marks a result typed in by hand
   typedef struct packed {
      logic             op;
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
      logic             known;
      logic [WIDTH-1:0] value;
   } corner_row_type;

   localparam int NUM_CORNERS = 22;

   corner_row_type corner_rows [NUM_CORNERS] = '{
      '{igl_pkg::OP_GCD, 32'sd0, 32'sd0, 1'b1, 32'sd0},
      '{igl_pkg::OP_LCM, 32'sd0, 32'sd0, 1'b1, 32'sd0},
      '{igl_pkg::OP_GCD, 32'sd0, 32'sd5, 1'b1, 32'sd5},
      '{igl_pkg::OP_GCD, 32'sd7, 32'sd0, 1'b1, 32'sd7},
      '{igl_pkg::OP_LCM, 32'sd0, 32'sd7, 1'b1, 32'sd0},
      '{igl_pkg::OP_GCD, MIN_VALUE, MIN_VALUE, 1'b1, MIN_VALUE},
      '{igl_pkg::OP_GCD, MIN_VALUE, 32'sd0, 1'b1, MIN_VALUE},
      '{igl_pkg::OP_GCD, -32'sd1, -32'sd1, 1'b1, 32'sd1},
      '{igl_pkg::OP_GCD, MAX_VALUE, MAX_VALUE, 1'b1, MAX_VALUE},
      '{igl_pkg::OP_LCM, MAX_VALUE, MAX_VALUE, 1'b1, MAX_VALUE},
      '{igl_pkg::OP_GCD, MIN_VALUE, MAX_VALUE, 1'b1, 32'sd1},
      '{igl_pkg::OP_LCM, MIN_VALUE, MAX_VALUE, 1'b1, MIN_VALUE},
      '{igl_pkg::OP_GCD, 32'sd12, -32'sd18, 1'b1, 32'sd6},
      '{igl_pkg::OP_LCM, -32'sd4, 32'sd6, 1'b1, 32'sd12},
      '{igl_pkg::OP_LCM, 32'sd3, -32'sd5, 1'b1, 32'sd15},
      '{igl_pkg::OP_GCD, MIN_VALUE, 32'hC000_0000, 1'b1, 32'h4000_0000},
      '{igl_pkg::OP_LCM, -32'sd1, MIN_VALUE, 1'b0, 32'sd0},
      '{igl_pkg::OP_LCM, 32'sd65536, 32'sd65537, 1'b0, 32'sd0},
      '{igl_pkg::OP_LCM, 32'sd65537, 32'sd65535, 1'b0, 32'sd0},
      '{igl_pkg::OP_GCD, 32'sd1836311903, 32'sd1134903170, 1'b1, 32'sd1},
      '{igl_pkg::OP_LCM, 32'sd1836311903, -32'sd1134903170, 1'b0, 32'sd0},
      '{igl_pkg::OP_LCM, 32'sd0, MIN_VALUE, 1'b0, 32'sd0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_op = igl_pkg::OP_GCD;
   logic signed [WIDTH-1:0] req_a = '0;
   logic signed [WIDTH-1:0] req_b = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [WIDTH-1:0] rsp_result;

   // result channel as seen just before each rising edge
   logic                    rsp_taken = 1'b0;
   logic [WIDTH-1:0]        rsp_word = '0;

   // expected results in order of acceptance
   logic [WIDTH-1:0] pending_results [$];

   int unsigned req_gap_max = 9;
   int unsigned rsp_wait_max = 9;
   int unsigned hold_request = 0;
   int unsigned rsp_wait_left = 0;
   int unsigned error_count = 0;
   int unsigned gcd_words = 0;
   int unsigned lcm_words = 0;
   int unsigned results_checked = 0;

   integer_gcd_lcm_unit #(
      .WIDTH(WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_a(req_a),
      .req_b(req_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result(rsp_result)
   );

   // clock, period 20
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // gcd of magnitudes by Euclid, or lcm wrapped to the word width
   function automatic logic [WIDTH-1:0] gcd_lcm_value(input logic op,
                                                      input logic [WIDTH-1:0] a,
                                                      input logic [WIDTH-1:0] b);
      logic [WIDTH-1:0] mag_a;
      logic [WIDTH-1:0] mag_b;
      logic [WIDTH-1:0] x;
      logic [WIDTH-1:0] y;
      logic [WIDTH-1:0] rem;
      logic [WIDTH-1:0] prod;
      mag_a = a[WIDTH-1] ? -a : a;
      mag_b = b[WIDTH-1] ? -b : b;
      x = mag_a;
      y = mag_b;
      while (x != '0) begin
         rem = y % x;
         y = x;
         x = rem;
      end
      if (op == igl_pkg::OP_GCD) return y;
      if (y == '0) return '0;
      prod = (mag_a / y) * mag_b;
      // negative pattern is folded back; the most negative stays as is
      if (prod[WIDTH-1]) prod = -prod;
      return prod;
   endfunction

   // operand drawn from a mix of classes
   function automatic logic [WIDTH-1:0] draw_operand();
      logic [WIDTH-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = MIN_VALUE;
         2: v = MAX_VALUE;
         3: v = $urandom_range(0, 1) ? -1 : 1;
         4: begin
            v = 1 << $urandom_range(0, WIDTH - 1);
            if ($urandom_range(0, 1)) v = -v;
         end
         5, 6: v = $urandom_range(0, 2000) - 1000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // offer one word after a random gap, push its expectation on acceptance
   task automatic send_word(input logic op, input logic [WIDTH-1:0] a,
                            input logic [WIDTH-1:0] b, input logic known,
                            input logic [WIDTH-1:0] value);
      int unsigned gap;
      logic        taken;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_a <= a;
      req_b <= b;
      // stall is steady between edges, so look at it mid-cycle
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      pending_results.push_back(known ? value : gcd_lcm_value(op, a, b));
      if (op == igl_pkg::OP_GCD) gcd_words++;
      else lcm_words++;
   endtask

   // random words; small operands keep each word short
   task automatic send_random_words(input int count, input bit small_only);
      logic             op;
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
      logic [WIDTH-1:0] factor;
      for (int i = 0; i < count; i++) begin
         op = 1'($urandom_range(0, 1));
         if (small_only) begin
            a = $urandom_range(0, 400) - 200;
            b = $urandom_range(0, 400) - 200;
         end else if ($urandom_range(0, 3) == 0) begin
            // shared factor so the gcd is not trivial
            factor = $urandom_range(1, 5000);
            a = factor * $urandom_range(0, 60000);
            b = factor * $urandom_range(0, 60000);
            if ($urandom_range(0, 1)) a = -a;
            if ($urandom_range(0, 1)) b = -b;
         end else begin
            a = draw_operand();
            b = draw_operand();
         end
         send_word(op, a, b, 1'b0, '0);
      end
   endtask

   // drop valid and wait until every expected result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // sample the result channel mid-cycle, where it is steady
   always @(negedge clock) begin
      rsp_taken = rsp_valid && !rsp_stall;
      rsp_word = rsp_result;
   end

   // result side: random stall per result, long hold on request, and checking
   always @(posedge clock) begin
      logic [WIDTH-1:0] expected;
      if (rsp_taken) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_word);
            error_count++;
         end else begin
            expected = pending_results.pop_front();
            results_checked++;
            if (expected !== rsp_word) begin
               $display("%0t: result mismatch, expected %h, actual %h",
                        $time, expected, rsp_word);
               error_count++;
            end
         end
      end
      if (hold_request != 0) begin
         rsp_wait_left = hold_request;
         hold_request = 0;
      end else if (rsp_taken) begin
         rsp_wait_left = $urandom_range(0, rsp_wait_max);
      end else if (rsp_wait_left > 0) begin
         rsp_wait_left--;
      end
      rsp_stall <= (rsp_wait_left > 0);
   end

   // stimulus sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // corner table
      for (int i = 0; i < NUM_CORNERS; i++) begin
         send_word(corner_rows[i].op, corner_rows[i].a, corner_rows[i].b,
                   corner_rows[i].known, corner_rows[i].value);
      end
      wait_drained();

      // random words with gaps and stalls
      send_random_words(600, 1'b0);

      // back to back, no gaps or stalls
      req_gap_max = 0;
      rsp_wait_max = 0;
      send_random_words(300, 1'b0);
      wait_drained();

      // long output hold while words keep coming, then a full pause
      req_gap_max = 3;
      rsp_wait_max = 9;
      hold_request = 3000;
      send_random_words(16, 1'b1);
      wait_drained();

      // random again to the end
      req_gap_max = 9;
      send_random_words(712, 1'b0);
      wait_drained();
      repeat (300) @(posedge clock);

      $display("covered %0d gcd and %0d lcm words, %0d results checked", gcd_words,
               lcm_words, results_checked);
      $display("corner operands, random operand classes, idle and stall phases, long hold");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run time limit
   initial begin
      #400000000;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/igl_pkg.sv
rtl/igl_divider.sv
rtl/integer_gcd_lcm_unit.sv
tb/integer_gcd_lcm_unit_test.sv
